FILE: rtl/ltpr_pkg.sv
// Shared types, widths and helpers for the laser triangulation point block.
package ltpr_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int QUO_W      = 32;
  localparam int DIM_W      = 13;
  localparam int MAX_W      = (PIXEL_BITS > 12) ? PIXEL_BITS : 12;
  localparam int DIFF_W     = MAX_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_DEPTH   = 3'd0,
    REG_K_HEIGHT  = 3'd1,
    REG_COT_BETA  = 3'd2,
    REG_ROT_OFS   = 3'd3,
    REG_IMG_COLS  = 3'd4,
    REG_IMG_ROWS  = 3'd5,
    REG_COS_THETA = 3'd6,
    REG_SIN_THETA = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]        k_depth;
    logic [23:0]        k_height;
    logic [23:0]        cot_beta;
    logic signed [31:0] rotation_offset;
    logic [DIM_W-1:0]   image_cols;
    logic [DIM_W-1:0]   image_rows;
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_theta;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_col;
    logic [PIXEL_BITS-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               bad_column;
  } out_item_t;

  // Data handed from one divider cell to the next
  typedef struct packed {
    logic                     valid;
    logic [DIM_W-1:0]         rem;
    logic [QUO_W-1:0]         quo;
    logic [DIM_W-1:0]         divisor;
    logic signed [DIFF_W-1:0] diff;
    logic                     bad;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: rtl/laser_triangulation_point_rotate_top.sv
// Top level: config registers, divider cell chain and output stages.
//
// One laser-line pixel (column, row) enters on the in channel and one
// Q16.16 point (x, y, z, bad_column) leaves on the out channel, both
// valid/ready. Configuration must be written via cfg_we_i/cfg_idx_i/
// cfg_wdata_i only while no item is in flight; the block won't check.
// Between acceptance and out_valid_o an item passes the chain of QUO_W
// restoring divider cells (one quotient bit per cell), then the
// multiply, rotate and saturate stages, each registered.
// Throughput: one item per cycle while the output is not stalled; every
// cell hands its item to the next cell each cycle that it is enabled.
// When the receiver stalls with a result waiting, the whole chain holds
// and in_ready_o drops; nothing is lost and no item is repeated.
// Reset clears all item valid bits and loads the registers with their
// defaults (cot_beta 1.0, 640 by 480 image, angle zero).
module laser_triangulation_point_rotate_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ltpr_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ltpr_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ltpr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ltpr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import ltpr_pkg::*;

  cfg_t cfg_q;
  div_t head;
  div_t chain [QUO_W+1];
  logic en;
  logic [MAX_W:0] col_x, cols_x;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_depth         <= '0;
      cfg_q.k_height        <= '0;
      cfg_q.cot_beta        <= 24'd65536;
      cfg_q.rotation_offset <= '0;
      cfg_q.image_cols      <= 13'd640;
      cfg_q.image_rows      <= 13'd480;
      cfg_q.cos_theta       <= 16'sd16384;
      cfg_q.sin_theta       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_K_DEPTH:   cfg_q.k_depth         <= cfg_wdata_i;
        REG_K_HEIGHT:  cfg_q.k_height        <= cfg_wdata_i[23:0];
        REG_COT_BETA:  cfg_q.cot_beta        <= cfg_wdata_i[23:0];
        REG_ROT_OFS:   cfg_q.rotation_offset <= cfg_wdata_i;
        REG_IMG_COLS:  cfg_q.image_cols      <= cfg_wdata_i[DIM_W-1:0];
        REG_IMG_ROWS:  cfg_q.image_rows      <= cfg_wdata_i[DIM_W-1:0];
        REG_COS_THETA: cfg_q.cos_theta       <= cfg_wdata_i[15:0];
        REG_SIN_THETA: cfg_q.sin_theta       <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_x  = (MAX_W+1)'(in_data_i.pixel_col);
    cols_x = (MAX_W+1)'(cfg_q.image_cols);
    head.valid   = in_valid_i;
    head.rem     = '0;
    head.quo     = '0;
    head.divisor = cfg_q.image_cols - DIM_W'(in_data_i.pixel_col);
    head.bad     = col_x >= cols_x;
    head.diff    = $signed({1'b0, MAX_W'(in_data_i.pixel_row)})
                 - $signed({1'b0, MAX_W'(cfg_q.image_rows[DIM_W-1:1])});
  end

  assign chain[0] = head;

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    ltpr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .kbit_i (cfg_q.k_depth[QUO_W-1-i]),
      .d_i    (chain[i]),
      .d_o    (chain[i+1])
    );
  end

  ltpr_math u_math (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .d_i     (chain[QUO_W]),
    .valid_o (out_valid_o),
    .item_o  (out_data_o)
  );
endmodule

FILE: rtl/ltpr_div_cell.sv
// One restoring division cell: takes one dividend bit, yields one quotient bit.
module ltpr_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          kbit_i,
  input  ltpr_pkg::div_t d_i,
  output ltpr_pkg::div_t d_o
);
  import ltpr_pkg::*;

  logic [DIM_W:0]   sh;
  logic             ge;
  logic [DIM_W:0]   sub;
  logic             valid_q;
  div_t             d_d, data_q;

  always_comb begin
    sh  = {d_i.rem, kbit_i};
    ge  = sh >= {1'b0, d_i.divisor};
    sub = sh - {1'b0, d_i.divisor};
    d_d = d_i;
    d_d.rem = ge ? sub[DIM_W-1:0] : sh[DIM_W-1:0];
    d_d.quo = {d_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= d_d;
    end
  end

  always_comb begin
    d_o       = data_q;
    d_o.valid = valid_q;
  end
endmodule

FILE: rtl/ltpr_math.sv
// Height, lateral offset, rotation and saturation stages after the divider.
module ltpr_math (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ltpr_pkg::cfg_t     cfg_i,
  input  ltpr_pkg::div_t     d_i,
  output logic               valid_o,
  output ltpr_pkg::out_item_t item_o
);
  import ltpr_pkg::*;

  localparam int TW = DIFF_W + 25;
  localparam int AW = TW + 17;
  localparam int SW = AW + 17;
  localparam int HW = SW - 24;
  localparam int LW = 42;

  // stage 1
  logic                 v1_q, bad1_q;
  logic [31:0]          dep1_q;
  logic signed [TW-1:0] t1_q;
  logic [55:0]          p1_q;
  // stage 2
  logic                 v2_q, bad2_q;
  logic [31:0]          dep2_q;
  logic signed [AW-1:0] a2_q, b2_q;
  logic signed [LW-1:0] lat2_q;
  // stage 3
  logic                 v3_q, bad3_q;
  logic signed [HW-1:0] h3_q;
  logic signed [57:0]   xl3_q, yl3_q;
  logic signed [48:0]   xd3_q, yd3_q;
  // stage 4
  logic                 v4_q;
  out_item_t            o4_q;

  logic signed [SW-1:0] hsum;
  logic signed [59:0]   xs, ys;
  logic signed [HW:0]   zn;
  out_item_t            o4_d;

  always_comb begin
    hsum = $signed({a2_q, 16'b0}) + SW'(b2_q);
    xs   = (60'(xl3_q) - 60'(xd3_q)) >>> 14;
    ys   = (60'(yl3_q) + 60'(yd3_q)) >>> 14;
    zn   = -((HW+1)'(h3_q));
    o4_d.bad_column = bad3_q;
    if (bad3_q) begin
      o4_d.point_x = '0;
      o4_d.point_y = '0;
      o4_d.point_z = '0;
    end else begin
      o4_d.point_x = sat32(64'(xs));
      o4_d.point_y = sat32(64'(ys));
      o4_d.point_z = sat32(64'(zn));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= d_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad1_q <= d_i.bad;
      dep1_q <= d_i.quo;
      t1_q   <= TW'(d_i.diff) * $signed({1'b0, cfg_i.k_height});
      p1_q   <= d_i.quo * cfg_i.cot_beta;

      bad2_q <= bad1_q;
      dep2_q <= dep1_q;
      a2_q   <= AW'(t1_q) * $signed({1'b0, dep1_q[31:16]});
      b2_q   <= AW'(t1_q) * $signed({1'b0, dep1_q[15:0]});
      lat2_q <= $signed({2'b0, p1_q[55:16]}) - LW'(cfg_i.rotation_offset);

      bad3_q <= bad2_q;
      h3_q   <= hsum[SW-1:24];
      xl3_q  <= 58'(lat2_q) * cfg_i.cos_theta;
      yl3_q  <= 58'(lat2_q) * cfg_i.sin_theta;
      xd3_q  <= 49'($signed({1'b0, dep2_q})) * cfg_i.sin_theta;
      yd3_q  <= 49'($signed({1'b0, dep2_q})) * cfg_i.cos_theta;

      o4_q   <= o4_d;
    end
  end

  assign valid_o = v4_q;
  assign item_o  = o4_q;
endmodule

FILE: rtl/ltpr_checker.sv
// Port-level checks for the triangulation block, bound to the top level.
module ltpr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ltpr_pkg::out_item_t out_data_o
);
  import ltpr_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // a stalled output must block new items
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item taken while output stalled");

  // a bad column yields a zero point
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_column |->
      out_data_o.point_x == 0 && out_data_o.point_y == 0 && out_data_o.point_z == 0)
    else $error("bad column with non-zero point");

endmodule

bind laser_triangulation_point_rotate_top ltpr_checker u_ltpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
